[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_ERROR     = 8'h45;
   localparam logic [7:0] ATTR_BLANK   = 8'h07;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_code;
      logic [7:0] attr;
      logic       use_position;
      logic [7:0] col;
      logic [7:0] row;
   } req_type;

   typedef struct packed {
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
      logic       position_error;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic fill;
      logic scroll;
      logic cnt_clear;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic scroll_needed;
      logic is_clear;
      logic cnt_last;
   } status_type;

endpackage

[rtl/tcw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: init fill, execute, scroll sweep, clear sweep, response beat.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output tcw_pkg::cmd_type    cmd,
   input  tcw_pkg::status_type status
);
   import tcw_pkg::*;

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_FILL   = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.fill = 1'b1;
            if (status.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec      = 1'b1;
            cmd.cnt_clear = 1'b1;
            if (status.is_clear) begin
               state_in = S_FILL;
            end else if (status.scroll_needed) begin
               state_in = S_SCROLL;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SCROLL: begin
            cmd.scroll = 1'b1;
            if (status.cnt_last) begin
               state_in = S_RESP;
            end
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            if (status.cnt_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_resp_single: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !cmd.respond)
      else $error("response strobe longer than one cycle");

   a_exec_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec)
      else $error("load not followed by execute");

endmodule

[rtl/tcw_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell memory, cursor, sweep counter and response formatting.
// ----------------------------------------------------------------------------
module tcw_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tcw_pkg::req_type    req_data,
   input  tcw_pkg::cmd_type    cmd,
   output tcw_pkg::status_type status,
   output tcw_pkg::rsp_type    rsp_data
);
   import tcw_pkg::*;

   logic [15:0]       mem [CELLS];
   logic [15:0]       rdata_ff;
   req_type           req_ff;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ADDR_W-1:0] cnt_ff;
   logic              wv_ff;
   logic              wzero_ff;
   logic [ADDR_W-1:0] waddr_ff;

   logic              off_grid;
   logic              put_ok;
   logic [ROW_W-1:0]  pos_row;
   logic [COL_W-1:0]  pos_col;
   logic [ROW_W:0]    nrow;
   logic [COL_W:0]    ncol;
   logic [ADDR_W-1:0] pos_addr;
   logic [ADDR_W-1:0] raddr;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [15:0]       wdata;
   logic              scroll_needed;

   assign off_grid = (int'(req_ff.col) >= COLUMNS) || (int'(req_ff.row) >= ROWS);
   assign put_ok   = (req_ff.opcode == OP_PUT) && !(req_ff.use_position && off_grid);
   assign pos_row  = req_ff.use_position ? req_ff.row[ROW_W-1:0] : row_ff;
   assign pos_col  = req_ff.use_position ? req_ff.col[COL_W-1:0] : col_ff;
   assign pos_addr = ADDR_W'(pos_row) * ADDR_W'(COLUMNS) + ADDR_W'(pos_col);

   always_comb begin
      nrow = {1'b0, pos_row};
      ncol = {1'b0, pos_col};
      priority if (req_ff.char_code == CH_NEWLINE) begin
         nrow = {1'b0, pos_row} + 1'b1;
         ncol = '0;
      end else if (req_ff.char_code == CH_BACKSPACE) begin
         nrow = {1'b0, pos_row};
      end else begin
         ncol = {1'b0, pos_col} + 1'b1;
         if (int'(ncol) == COLUMNS) begin
            ncol = '0;
            nrow = {1'b0, pos_row} + 1'b1;
         end
      end
      scroll_needed = (int'(nrow) == ROWS);
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.exec && (req_ff.opcode == OP_CLEAR)) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.exec && put_ok) begin
         row_in = scroll_needed ? ROW_W'(ROWS - 1) : nrow[ROW_W-1:0];
         col_in = ncol[COL_W-1:0];
      end
   end

   always_comb begin
      we    = 1'b0;
      waddr = cnt_ff;
      wdata = {ATTR_BLANK, CH_SPACE};
      priority if (wv_ff) begin
         we    = 1'b1;
         waddr = waddr_ff;
         wdata = wzero_ff ? 16'h0000 : rdata_ff;
      end else if (cmd.fill) begin
         we = 1'b1;
      end else if (cmd.exec && (req_ff.opcode == OP_PUT)) begin
         if (!put_ok) begin
            we    = 1'b1;
            waddr = ADDR_W'(CELLS - 1);
            wdata = {req_ff.attr, CH_ERROR};
         end else if (req_ff.char_code == CH_BACKSPACE) begin
            we    = 1'b1;
            waddr = pos_addr;
            wdata = {req_ff.attr, CH_SPACE};
         end else if (req_ff.char_code != CH_NEWLINE) begin
            we    = 1'b1;
            waddr = pos_addr;
            wdata = {req_ff.attr, req_ff.char_code};
         end
      end else begin
         we = 1'b0;
      end
   end

   always_comb begin
      if (cmd.scroll) begin
         raddr = (int'(cnt_ff) < CELLS - COLUMNS) ? cnt_ff + ADDR_W'(COLUMNS) : '0;
      end else begin
         raddr = off_grid ? '0
               : ADDR_W'(req_ff.row[ROW_W-1:0]) * ADDR_W'(COLUMNS)
                 + ADDR_W'(req_ff.col[COL_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      waddr_ff <= cnt_ff;
      wzero_ff <= (int'(cnt_ff) >= CELLS - COLUMNS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         cnt_ff <= '0;
         wv_ff  <= 1'b0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         wv_ff  <= cmd.scroll;
         if (cmd.cnt_clear) begin
            cnt_ff <= '0;
         end else if (cmd.fill || cmd.scroll) begin
            cnt_ff <= (int'(cnt_ff) == CELLS - 1) ? '0 : cnt_ff + 1'b1;
         end
      end
   end

   assign status.scroll_needed = put_ok && scroll_needed;
   assign status.is_clear      = (req_ff.opcode == OP_CLEAR);
   assign status.cnt_last      = (int'(cnt_ff) == CELLS - 1);

   always_comb begin
      rsp_data            = '0;
      rsp_data.cursor_row = row_ff;
      rsp_data.cursor_col = col_ff;
      if (req_ff.opcode == OP_READ) begin
         rsp_data.position_error = off_grid;
         if (!off_grid) begin
            rsp_data.cell_char = rdata_ff[7:0];
            rsp_data.cell_attr = rdata_ff[15:8];
         end
      end else if (req_ff.opcode == OP_PUT) begin
         rsp_data.position_error = req_ff.use_position && off_grid;
      end
   end

   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      (int'(row_ff) < ROWS) && (int'(col_ff) < COLUMNS))
      else $error("cursor outside grid");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      we |-> (int'(waddr) < CELLS))
      else $error("cell write out of range");

   a_scroll_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd.scroll && status.cnt_last) |=> (wv_ff && !cmd.scroll))
      else $error("scroll sweep ended without draining last write");

endmodule

[rtl/text_console_writer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console: 80x25 cell grid with cursor, put, read and clear.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; its result appears on
// rsp_data for the single cycle rsp_valid is high and cannot be held off.
// After reset the block is busy while it blanks the cell memory. A put that
// does not scroll, a read and an unused opcode pass through execute and a
// response state; the next beat is taken only once busy has dropped. A put
// that scrolls and a clear both sweep the whole memory one cell per cycle
// through its single write port before their result is given.
module text_console_writer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   output tcw_pkg::rsp_type rsp_data
);
   import tcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   tcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   tcw_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   assign rsp_valid = cmd.respond;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for text_console_writer_core. A short table of
// directed commands (reset contents, grid corners, off-grid puts and reads,
// backspace, newline, scroll, clear, unused opcode) is followed by random
// command streams that keep the cursor moving into scrolls. Every accepted
// command runs through a cycle-free model of the console; each response
// strobe is compared field by field with the oldest table or model response.
// ----------------------------------------------------------------------------
module tb_top;
   import tcw_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_CMDS  = 450;
   localparam int LIMIT_CYCLES = 5_000_000;

   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic [15:0]  screen_image [CELLS];
   int unsigned  cursor_pos;
   rsp_type      console_rsp_q [$];
   stim_row_type directed_rows [$];
   int           mismatch_count;
   int           cycle_count;

   text_console_writer_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic req_type mk_cmd(logic [1:0] op, logic [7:0] ch, logic [7:0] at,
                                      logic use_pos, logic [7:0] c, logic [7:0] r);
      req_type q;
      q.opcode       = op;
      q.char_code    = ch;
      q.attr         = at;
      q.use_position = use_pos;
      q.col          = c;
      q.row          = r;
      return q;
   endfunction

   function automatic rsp_type mk_status(int unsigned crow, int unsigned ccol,
                                         logic [7:0] ch, logic [7:0] at, logic err);
      rsp_type s;
      s.cursor_row     = ROW_W'(crow);
      s.cursor_col     = COL_W'(ccol);
      s.cell_char      = ch;
      s.cell_attr      = at;
      s.position_error = err;
      return s;
   endfunction

   // console model: updates the screen image and cursor, returns the response
   function automatic rsp_type apply_console_op(req_type r);
      rsp_type     o;
      int unsigned pos;
      bit          off_grid;
      o = '0;
      off_grid = (r.col >= COLUMNS) || (r.row >= ROWS);
      case (r.opcode)
         OP_PUT: begin
            if (r.use_position && off_grid) begin
               screen_image[CELLS-1] = {r.attr, CH_ERROR};
               o.position_error = 1'b1;
            end else begin
               pos = r.use_position ? r.row * COLUMNS + r.col : cursor_pos;
               if (r.char_code == CH_NEWLINE) begin
                  pos = (pos / COLUMNS + 1) * COLUMNS;
               end else if (r.char_code == CH_BACKSPACE) begin
                  screen_image[pos] = {r.attr, CH_SPACE};
               end else begin
                  screen_image[pos] = {r.attr, r.char_code};
                  pos++;
               end
               if (pos >= CELLS) begin
                  for (int i = 0; i < CELLS - COLUMNS; i++)
                     screen_image[i] = screen_image[i+COLUMNS];
                  for (int i = CELLS - COLUMNS; i < CELLS; i++)
                     screen_image[i] = '0;
                  pos -= COLUMNS;
               end
               cursor_pos = pos;
            end
         end
         OP_READ: begin
            if (off_grid) begin
               o.position_error = 1'b1;
            end else begin
               o.cell_char = screen_image[r.row * COLUMNS + r.col][7:0];
               o.cell_attr = screen_image[r.row * COLUMNS + r.col][15:8];
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++)
               screen_image[i] = {ATTR_BLANK, CH_SPACE};
            cursor_pos = 0;
         end
         default: ;
      endcase
      o.cursor_row = ROW_W'(cursor_pos / COLUMNS);
      o.cursor_col = COL_W'(cursor_pos % COLUMNS);
      return o;
   endfunction

   function automatic req_type pick_random_cmd();
      req_type     q;
      int unsigned sel;
      int unsigned near;
      q   = mk_cmd(OP_PUT, 8'($urandom), 8'($urandom), 1'b0, 8'($urandom), 8'($urandom));
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         // cursor put, newline-heavy so the cursor reaches the bottom and scrolls
         case ($urandom_range(0, 9))
            0, 1:    q.char_code = CH_NEWLINE;
            2:       q.char_code = CH_BACKSPACE;
            default: ;
         endcase
      end else if (sel < 60) begin
         q.use_position = 1'b1;
         q.row = ($urandom_range(0, 3) == 0) ? 8'(ROWS - 1) : 8'($urandom_range(0, ROWS - 1));
         q.col = ($urandom_range(0, 3) == 0) ? 8'(COLUMNS - 1)
                                             : 8'($urandom_range(0, COLUMNS - 1));
         if ($urandom_range(0, 4) == 0)
            q.char_code = ($urandom_range(0, 1) == 0) ? CH_NEWLINE : CH_BACKSPACE;
      end else if (sel < 65) begin
         q.use_position = 1'b1;
         if ($urandom_range(0, 1) == 0)
            q.col = 8'($urandom_range(COLUMNS, 255));
         else
            q.row = 8'($urandom_range(ROWS, 255));
      end else if (sel < 87) begin
         q.opcode = OP_READ;
         if ($urandom_range(0, 1) == 0) begin
            near  = (cursor_pos == 0) ? 0 : cursor_pos - $urandom_range(1, 3) % (cursor_pos + 1);
            q.row = 8'(near / COLUMNS);
            q.col = 8'(near % COLUMNS);
         end else begin
            q.row = 8'($urandom_range(0, ROWS - 1));
            q.col = 8'($urandom_range(0, COLUMNS - 1));
         end
      end else if (sel < 92) begin
         q.opcode = OP_READ;
         if ($urandom_range(0, 1) == 0)
            q.col = 8'($urandom_range(COLUMNS, 255));
         else
            q.row = 8'($urandom_range(ROWS, 255));
      end else if (sel < 95) begin
         q.opcode = OP_UNUSED;
      end else if (sel < 97) begin
         q.opcode = OP_CLEAR;
      end else begin
         q.use_position = 1'b1;
      end
      return q;
   endfunction

   task automatic add_row(req_type c, bit typed, rsp_type w);
      stim_row_type e;
      e.cmd   = c;
      e.typed = typed;
      e.want  = w;
      directed_rows.push_back(e);
   endtask

   task automatic send_beat(req_type c, bit typed, rsp_type w);
      int      gap;
      rsp_type predicted;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= c;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_console_op(c);
      console_rsp_q.push_back(typed ? w : predicted);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid === 1'b1) begin
         if (console_rsp_q.size() == 0) begin
            $error("response with nothing expected: %h", rsp_data);
            mismatch_count++;
         end else begin
            e = console_rsp_q.pop_front();
            if (rsp_data.cursor_row !== e.cursor_row) begin
               $error("cursor_row expected %0d got %0d", e.cursor_row, rsp_data.cursor_row);
               mismatch_count++;
            end
            if (rsp_data.cursor_col !== e.cursor_col) begin
               $error("cursor_col expected %0d got %0d", e.cursor_col, rsp_data.cursor_col);
               mismatch_count++;
            end
            if (rsp_data.cell_char !== e.cell_char) begin
               $error("cell_char expected %h got %h", e.cell_char, rsp_data.cell_char);
               mismatch_count++;
            end
            if (rsp_data.cell_attr !== e.cell_attr) begin
               $error("cell_attr expected %h got %h", e.cell_attr, rsp_data.cell_attr);
               mismatch_count++;
            end
            if (rsp_data.position_error !== e.position_error) begin
               $error("position_error expected %b got %b",
                      e.position_error, rsp_data.position_error);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      mismatch_count = 0;
      cursor_pos     = 0;
      for (int i = 0; i < CELLS; i++)
         screen_image[i] = {ATTR_BLANK, CH_SPACE};

      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0), 1'b1,
              mk_status(0, 0, CH_SPACE, ATTR_BLANK, 1'b0));
      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b1, 8'd79, 8'd24), 1'b1,
              mk_status(0, 0, CH_SPACE, ATTR_BLANK, 1'b0));
      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd80, 8'd0), 1'b1,
              mk_status(0, 0, 8'h00, 8'h00, 1'b1));
      add_row(mk_cmd(OP_READ, 8'hFF, 8'hFF, 1'b1, 8'd255, 8'd255), 1'b1,
              mk_status(0, 0, 8'h00, 8'h00, 1'b1));
      add_row(mk_cmd(OP_PUT, 8'h41, 8'hFF, 1'b0, 8'd0, 8'd0), 1'b1,
              mk_status(0, 1, 8'h00, 8'h00, 1'b0));
      add_row(mk_cmd(OP_PUT, CH_BACKSPACE, 8'h1E, 1'b0, 8'd0, 8'd0), 1'b1,
              mk_status(0, 1, 8'h00, 8'h00, 1'b0));
      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd1, 8'd0), 1'b1,
              mk_status(0, 1, CH_SPACE, 8'h1E, 1'b0));
      add_row(mk_cmd(OP_PUT, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0), 1'b0, '0);
      add_row(mk_cmd(OP_PUT, CH_NEWLINE, 8'h00, 1'b0, 8'd0, 8'd0), 1'b1,
              mk_status(1, 0, 8'h00, 8'h00, 1'b0));
      add_row(mk_cmd(OP_PUT, 8'hFF, 8'h80, 1'b1, 8'd79, 8'd0), 1'b1,
              mk_status(1, 0, 8'h00, 8'h00, 1'b0));
      add_row(mk_cmd(OP_PUT, 8'h5A, 8'h4F, 1'b1, 8'd80, 8'd0), 1'b1,
              mk_status(1, 0, 8'h00, 8'h00, 1'b1));
      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd24), 1'b1,
              mk_status(1, 0, CH_ERROR, 8'h4F, 1'b0));
      add_row(mk_cmd(OP_PUT, 8'h00, 8'h01, 1'b1, 8'd0, 8'd25), 1'b1,
              mk_status(1, 0, 8'h00, 8'h00, 1'b1));
      add_row(mk_cmd(OP_PUT, 8'h78, 8'h70, 1'b0, 8'hFF, 8'hFF), 1'b1,
              mk_status(1, 1, 8'h00, 8'h00, 1'b0));
      add_row(mk_cmd(OP_UNUSED, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b1,
              mk_status(1, 1, 8'h00, 8'h00, 1'b0));
      // last cell written, cursor runs past the end: scroll
      add_row(mk_cmd(OP_PUT, 8'h51, 8'h2A, 1'b1, 8'd79, 8'd24), 1'b1,
              mk_status(24, 0, 8'h00, 8'h00, 1'b0));
      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd24), 1'b1,
              mk_status(24, 0, 8'h00, 8'h00, 1'b0));
      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd23), 1'b1,
              mk_status(24, 0, 8'h51, 8'h2A, 1'b0));
      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0), 1'b0, '0);
      add_row(mk_cmd(OP_PUT, CH_NEWLINE, 8'h55, 1'b0, 8'd0, 8'd0), 1'b0, '0);
      add_row(mk_cmd(OP_PUT, CH_NEWLINE, 8'hAA, 1'b1, 8'd0, 8'd24), 1'b0, '0);
      add_row(mk_cmd(OP_PUT, CH_BACKSPACE, 8'hC3, 1'b1, 8'd78, 8'd24), 1'b0, '0);
      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd78, 8'd24), 1'b0, '0);
      add_row(mk_cmd(OP_CLEAR, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0), 1'b1,
              mk_status(0, 0, 8'h00, 8'h00, 1'b0));
      add_row(mk_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd24), 1'b1,
              mk_status(0, 0, CH_SPACE, ATTR_BLANK, 1'b0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
      repeat (RANDOM_CMDS)
         send_beat(pick_random_cmd(), 1'b0, '0);
      start <= 1'b0;

      while (console_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
